// File: hdl/circle_wall_pushout_macros.svh
// Assertion macros for cwp_back, the block that checks itself.
`ifndef CIRCLE_WALL_PUSHOUT_MACROS_SVH
`define CIRCLE_WALL_PUSHOUT_MACROS_SVH

// An implication checked at every clock edge outside reset.
`define CWP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication checked in the cycle after its antecedent.
`define CWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/cwp_pkg.sv
`default_nettype none
package cwp_pkg;
    localparam int unsigned CoordW = 32;
    localparam int unsigned RadW   = 31;
    // Squared distances are held in SqW+1 = (2*CoordW)+1 bits, which covers a sum of two squares.
    localparam int unsigned SqW    = 64;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SIDE  = 2'd1,
        KIND_FIRST = 2'd2,
        KIND_SECOND = 2'd3
    } t_kind;

    // Classification that the front hands to the back.
    typedef struct packed {
        logic                     side;
        logic                     near_a;
        logic                     near_b;
        logic signed [CoordW:0]   ax;
        logic signed [CoordW:0]   ay;
        logic signed [CoordW:0]   bx;
        logic signed [CoordW:0]   by;
        logic signed [CoordW:0]   px;
        logic signed [CoordW:0]   py;
        logic signed [CoordW+1:0] side_x;
        logic signed [CoordW+1:0] side_y;
        logic [RadW-1:0]          r;
    } t_front;

    function automatic logic signed [CoordW-1:0] sat_c(input logic signed [CoordW+1:0] v);
        logic signed [CoordW+1:0] mx;
        logic signed [CoordW+1:0] mn;
        mx = (CoordW+2)'((64'sd1 <<< (CoordW-1)) - 64'sd1);
        mn = -mx - (CoordW+2)'(1);
        if (v > mx) begin
            return mx[CoordW-1:0];
        end
        if (v < mn) begin
            return mn[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction
endpackage
`default_nettype wire

// File: hdl/cwp_front.sv
`default_nettype none
// Orders the endpoints, decides the side case and computes the endpoint
// nearness tests over two pipeline stages.
module cwp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic signed [31:0]           i_ax,
    input  wire logic signed [31:0]           i_ay,
    input  wire logic signed [31:0]           i_bx,
    input  wire logic signed [31:0]           i_by,
    input  wire logic signed [31:0]           i_px,
    input  wire logic signed [31:0]           i_py,
    input  wire logic [30:0]                  i_r,
    output logic                              o_valid,
    output cwp_pkg::t_front                   o_item
);
    import cwp_pkg::*;

    // Stage one: ordering and side band.
    logic r_v1;
    logic signed [CoordW:0] r_ax, r_ay, r_bx, r_by, r_px, r_py;
    logic [RadW-1:0] r_r;
    logic r_side;
    logic signed [CoordW+1:0] r_sx, r_sy;

    logic signed [CoordW:0] ax, ay, bx, by, px, py, ri;
    logic aligned, side, vert;
    logic signed [CoordW+1:0] sx, sy;

    always_comb begin
        ax = {i_ax[31], i_ax};
        ay = {i_ay[31], i_ay};
        bx = {i_bx[31], i_bx};
        by = {i_by[31], i_by};
        px = {i_px[31], i_px};
        py = {i_py[31], i_py};
        ri = {2'b00, i_r};
        aligned = (ax == bx) || (ay == by);
        if (aligned && (ay > by)) begin
            ay = {i_by[31], i_by};
            by = {i_ay[31], i_ay};
        end
        if (aligned && (ax > bx)) begin
            ax = {i_bx[31], i_bx};
            bx = {i_ax[31], i_ax};
        end
        vert = (ax == bx);
        sx = (px < ax) ? ({ax[CoordW], ax} - {ri[CoordW], ri})
                       : ({ax[CoordW], ax} + {ri[CoordW], ri});
        sy = (py < ay) ? ({ay[CoordW], ay} - {ri[CoordW], ri})
                       : ({ay[CoordW], ay} + {ri[CoordW], ri});
        if (vert) begin
            side = ($signed({ax[CoordW], ax}) - $signed({ri[CoordW], ri})
                        < $signed({px[CoordW], px})) &&
                   ($signed({px[CoordW], px})
                        < $signed({ax[CoordW], ax}) + $signed({ri[CoordW], ri})) &&
                   (ay <= py) && (py <= by);
        end else begin
            side = ($signed({ay[CoordW], ay}) - $signed({ri[CoordW], ri})
                        < $signed({py[CoordW], py})) &&
                   ($signed({py[CoordW], py})
                        < $signed({ay[CoordW], ay}) + $signed({ri[CoordW], ri})) &&
                   (ax <= px) && (px <= bx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_ax <= ax; r_ay <= ay; r_bx <= bx; r_by <= by;
        r_px <= px; r_py <= py; r_r <= i_r; r_side <= side;
        r_sx <= sx; r_sy <= sy;
    end

    // Stage two: squared distances against r*r. A component at or above r
    // already fails the test, so only the low radius bits are squared.
    logic [CoordW:0] adxa, adya, adxb, adyb;
    logic signed [CoordW+1:0] dxa, dya, dxb, dyb;
    logic [SqW:0] sa, sb, rr;
    logic na, nb;

    always_comb begin
        dxa = {r_px[CoordW], r_px} - {r_ax[CoordW], r_ax};
        dya = {r_py[CoordW], r_py} - {r_ay[CoordW], r_ay};
        dxb = {r_px[CoordW], r_px} - {r_bx[CoordW], r_bx};
        dyb = {r_py[CoordW], r_py} - {r_by[CoordW], r_by};
        adxa = dxa[CoordW+1] ? (CoordW+1)'(-dxa) : dxa[CoordW:0];
        adya = dya[CoordW+1] ? (CoordW+1)'(-dya) : dya[CoordW:0];
        adxb = dxb[CoordW+1] ? (CoordW+1)'(-dxb) : dxb[CoordW:0];
        adyb = dyb[CoordW+1] ? (CoordW+1)'(-dyb) : dyb[CoordW:0];
        rr = (SqW+1)'(64'(r_r) * 64'(r_r));
        sa = (SqW+1)'(64'(adxa[RadW-1:0]) * 64'(adxa[RadW-1:0])
                    + 64'(adya[RadW-1:0]) * 64'(adya[RadW-1:0]));
        sb = (SqW+1)'(64'(adxb[RadW-1:0]) * 64'(adxb[RadW-1:0])
                    + 64'(adyb[RadW-1:0]) * 64'(adyb[RadW-1:0]));
        na = (adxa < (CoordW+1)'(r_r)) && (adya < (CoordW+1)'(r_r)) && (sa < rr);
        nb = (adxb < (CoordW+1)'(r_r)) && (adyb < (CoordW+1)'(r_r)) && (sb < rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_item.side   <= r_side;
        o_item.near_a <= na;
        o_item.near_b <= nb;
        o_item.ax <= r_ax; o_item.ay <= r_ay;
        o_item.bx <= r_bx; o_item.by <= r_by;
        o_item.px <= r_px; o_item.py <= r_py;
        o_item.side_x <= r_sx; o_item.side_y <= r_sy;
        o_item.r <= r_r;
    end
endmodule
`default_nettype wire

// File: hdl/cwp_back.sv
`default_nettype none
// Carries out the push: side move or a radial endpoint move. The endpoint
// offset is a pipelined normalized root and a pipelined quotient, one
// stage per result bit.
module cwp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  cwp_pkg::t_front      i_item,
    output logic                 o_valid,
    output logic signed [31:0]   o_x,
    output logic signed [31:0]   o_y,
    output logic [1:0]           o_kind
);
    import cwp_pkg::*;
    `include "circle_wall_pushout_macros.svh"

    localparam int unsigned Nk  = 32;   // shift stages for normalizing
    localparam int unsigned Nr  = 32;   // root bits
    localparam int unsigned Nq  = 34;   // quotient bits (offset < 2^33)
    localparam int unsigned NumW = 96;

    typedef struct packed {
        logic                     v;
        logic [1:0]               kind;
        logic                     zero;
        logic signed [CoordW:0]   ex;
        logic signed [CoordW:0]   ey;
        logic                     sgx;
        logic                     sgy;
        logic [CoordW:0]          adx;
        logic [CoordW:0]          ady;
        logic [RadW-1:0]          r;
        logic signed [CoordW+1:0] ox;
        logic signed [CoordW+1:0] oy;
    } t_ctx;

    // Stage zero: pick the case and the endpoint.
    t_ctx c0;
    logic [63:0] s0;
    always_comb begin
        logic signed [CoordW+1:0] dx, dy;
        logic use_a;
        c0 = '0;
        c0.v = i_valid;
        c0.r = i_item.r;
        c0.ox = {i_item.px[CoordW], i_item.px};
        c0.oy = {i_item.py[CoordW], i_item.py};
        use_a = i_item.near_a;
        c0.ex = use_a ? i_item.ax : i_item.bx;
        c0.ey = use_a ? i_item.ay : i_item.by;
        dx = {i_item.px[CoordW], i_item.px} - {c0.ex[CoordW], c0.ex};
        dy = {i_item.py[CoordW], i_item.py} - {c0.ey[CoordW], c0.ey};
        c0.sgx = dx[CoordW+1];
        c0.sgy = dy[CoordW+1];
        c0.adx = dx[CoordW+1] ? (CoordW+1)'(-dx) : dx[CoordW:0];
        c0.ady = dy[CoordW+1] ? (CoordW+1)'(-dy) : dy[CoordW:0];
        s0 = 64'(c0.adx[RadW-1:0]) * 64'(c0.adx[RadW-1:0])
           + 64'(c0.ady[RadW-1:0]) * 64'(c0.ady[RadW-1:0]);
        c0.zero = (s0 == 64'd0);
        if (i_item.side) begin
            c0.kind = KIND_SIDE;
            if (i_item.ax == i_item.bx) begin
                c0.ox = i_item.side_x;
            end else begin
                c0.oy = i_item.side_y;
            end
        end else if (i_item.near_a) begin
            c0.kind = KIND_FIRST;
        end else if (i_item.near_b) begin
            c0.kind = KIND_SECOND;
        end else begin
            c0.kind = KIND_NONE;
        end
    end

    // Normalize: shift s left by two until bit 62 or 63 is set.
    t_ctx       r_nc [Nk+1];
    logic [63:0] r_nt [Nk+1];
    logic [5:0]  r_nk [Nk+1];
    always_ff @(posedge i_clk) begin
        t_ctx n_c;
        n_c = c0;
        if (!i_rst_n) begin
            n_c.v = 1'b0;
        end
        r_nc[0] <= n_c;
        r_nt[0] <= s0;
        r_nk[0] <= '0;
    end
    for (genvar g = 0; g < Nk; g++) begin : g_norm
        always_ff @(posedge i_clk) begin
            t_ctx n_c;
            n_c = r_nc[g];
            if (!i_rst_n) begin
                n_c.v = 1'b0;
            end
            r_nc[g+1] <= n_c;
            if ((r_nt[g] < (64'd1 << 62)) && (r_nt[g] != 64'd0)) begin
                r_nt[g+1] <= r_nt[g] << 2;
                r_nk[g+1] <= r_nk[g] + 6'd1;
            end else begin
                r_nt[g+1] <= r_nt[g];
                r_nk[g+1] <= r_nk[g];
            end
        end
    end

    // Root: restoring square root, one result bit per stage.
    t_ctx        r_rc [Nr+1];
    logic [63:0] r_rn [Nr+1];
    logic [63:0] r_rs [Nr+1];
    logic [5:0]  r_rk [Nr+1];
    always_comb begin
        r_rc[0] = r_nc[Nk];
        r_rn[0] = r_nt[Nk];
        r_rs[0] = '0;
        r_rk[0] = r_nk[Nk];
    end
    for (genvar g = 0; g < Nr; g++) begin : g_root
        localparam logic [63:0] Bit = 64'd1 << (62 - 2*g);
        always_ff @(posedge i_clk) begin
            t_ctx n_c;
            n_c = r_rc[g];
            if (!i_rst_n) begin
                n_c.v = 1'b0;
            end
            r_rc[g+1] <= n_c;
            r_rk[g+1] <= r_rk[g];
            if (r_rn[g] >= r_rs[g] + Bit) begin
                r_rn[g+1] <= r_rn[g] - (r_rs[g] + Bit);
                r_rs[g+1] <= (r_rs[g] >> 1) + Bit;
            end else begin
                r_rn[g+1] <= r_rn[g];
                r_rs[g+1] <= r_rs[g] >> 1;
            end
        end
    end

    // Numerators: (|d| << k) * r + root/2, one 31x31 product each.
    t_ctx        r_mc;
    logic [63:0] r_mroot;
    logic [NumW-1:0] r_numx, r_numy;
    always_ff @(posedge i_clk) begin
        logic [63:0] root;
        t_ctx n_c;
        root = r_rs[Nr];
        n_c = r_rc[Nr];
        if (!i_rst_n) begin
            n_c.v = 1'b0;
        end
        r_mc <= n_c;
        r_mroot <= (root == 64'd0) ? 64'd1 : root;
        r_numx <= ((NumW'(64'(r_rc[Nr].adx[RadW-1:0]) * 64'(r_rc[Nr].r))) << r_rk[Nr])
                + NumW'(root >> 1);
        r_numy <= ((NumW'(64'(r_rc[Nr].ady[RadW-1:0]) * 64'(r_rc[Nr].r))) << r_rk[Nr])
                + NumW'(root >> 1);
    end

    // Quotients: restoring division, one quotient bit per stage.
    t_ctx            r_qc [Nq+1];
    logic [63:0]     r_qd [Nq+1];
    logic [NumW-1:0] r_qxr [Nq+1];
    logic [NumW-1:0] r_qyr [Nq+1];
    logic [Nq-1:0]   r_qx [Nq+1];
    logic [Nq-1:0]   r_qy [Nq+1];
    always_comb begin
        r_qc[0] = r_mc;
        r_qd[0] = r_mroot;
        r_qxr[0] = r_numx;
        r_qyr[0] = r_numy;
        r_qx[0] = '0;
        r_qy[0] = '0;
    end
    for (genvar g = 0; g < Nq; g++) begin : g_div
        localparam int unsigned Sh = Nq - 1 - g;
        always_ff @(posedge i_clk) begin
            logic [NumW-1:0] dsh;
            t_ctx n_c;
            logic [Nq-1:0] n_qx;
            logic [Nq-1:0] n_qy;
            dsh = NumW'(r_qd[g]) << Sh;
            n_c = r_qc[g];
            if (!i_rst_n) begin
                n_c.v = 1'b0;
            end
            n_qx = r_qx[g];
            n_qy = r_qy[g];
            r_qc[g+1] <= n_c;
            r_qd[g+1] <= r_qd[g];
            if (r_qxr[g] >= dsh) begin
                r_qxr[g+1] <= r_qxr[g] - dsh;
                n_qx[Sh] = 1'b1;
            end else begin
                r_qxr[g+1] <= r_qxr[g];
            end
            if (r_qyr[g] >= dsh) begin
                r_qyr[g+1] <= r_qyr[g] - dsh;
                n_qy[Sh] = 1'b1;
            end else begin
                r_qyr[g+1] <= r_qyr[g];
            end
            r_qx[g+1] <= n_qx;
            r_qy[g+1] <= n_qy;
        end
    end

    // Final: apply offsets and saturate.
    t_ctx c_f;
    logic signed [CoordW+1:0] fx, fy, offx, offy;
    always_comb begin
        c_f = r_qc[Nq];
        offx = (CoordW+2)'(r_qx[Nq]);
        offy = (CoordW+2)'(r_qy[Nq]);
        fx = c_f.ox;
        fy = c_f.oy;
        if ((c_f.kind == KIND_FIRST) || (c_f.kind == KIND_SECOND)) begin
            if (c_f.zero) begin
                fx = {c_f.ex[CoordW], c_f.ex};
                fy = {c_f.ey[CoordW], c_f.ey};
            end else begin
                fx = c_f.sgx ? {c_f.ex[CoordW], c_f.ex} - offx
                             : {c_f.ex[CoordW], c_f.ex} + offx;
                fy = c_f.sgy ? {c_f.ey[CoordW], c_f.ey} - offy
                             : {c_f.ey[CoordW], c_f.ey} + offy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= c_f.v;
        end
        o_x <= sat_c(fx);
        o_y <= sat_c(fy);
        o_kind <= c_f.kind;
    end

    `CWP_ASSERT_NEXT(a_valid_follows, i_clk, i_rst_n, c_f.v, o_valid)
    `CWP_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !c_f.v, !o_valid)
    `CWP_ASSERT_IMP(a_root_nonzero, i_clk, i_rst_n, r_mc.v, r_mroot != 64'd0)
endmodule
`default_nettype wire

// File: hdl/circle_wall_pushout.sv
`default_nettype none
// Channel   Direction  Handshake              Beat
// command   in         i_start, o_busy       wall, disc centre, radius
// result    out        o_done (strobe)       pushed centre, contact, kind
//
// One beat is accepted every cycle; o_busy is held low for every supported
// fraction width. The o_done strobe of a command follows the edge that
// accepts it through two front stages, the capture stage of the back, 32
// normalizing stages, 32 root stages, one numerator stage, 34 quotient stages
// and the output register. Reset is synchronous, active low, and clears only
// the valid bits. The receiver cannot stall, so no back pressure exists.
module circle_wall_pushout #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_wall_ax,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_wall_ay,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_wall_bx,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_wall_by,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_disc_x,
    input  wire logic signed [cwp_pkg::CoordW-1:0] i_disc_y,
    input  wire logic [30:0]                       i_disc_radius,
    output logic                                   o_done,
    output logic signed [cwp_pkg::CoordW-1:0]      o_out_x,
    output logic signed [cwp_pkg::CoordW-1:0]      o_out_y,
    output logic                                   o_contact,
    output logic [1:0]                             o_contact_kind
);
    import cwp_pkg::*;

    // The datapath is exact integer arithmetic; the binary point does not
    // change any result, so it is only checked for being in range.
    localparam bit FracOk = (FRACTION_BITS >= 4) && (FRACTION_BITS <= 24);

    t_front front_item;
    logic   front_valid;
    logic   back_valid;
    logic [1:0] back_kind;
    logic signed [31:0] back_x, back_y;

    assign o_busy = !FracOk;

    cwp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_ax    (i_wall_ax),
        .i_ay    (i_wall_ay),
        .i_bx    (i_wall_bx),
        .i_by    (i_wall_by),
        .i_px    (i_disc_x),
        .i_py    (i_disc_y),
        .i_r     (i_disc_radius),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    cwp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (back_valid),
        .o_x     (back_x),
        .o_y     (back_y),
        .o_kind  (back_kind)
    );

    assign o_done         = back_valid;
    assign o_out_x        = back_x;
    assign o_out_y        = back_y;
    assign o_contact_kind = back_kind;
    assign o_contact      = (back_kind != KIND_NONE);
endmodule
`default_nettype wire
